// File: src/tfrb_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfrb_pkg
// Shared types and constants for the timestamped frame ring blend core.
// ---------------------------------------------------------------------------
package tfrb_pkg;

    localparam int RING_SLOTS      = 8;
    localparam int SLOT_W          = $clog2(RING_SLOTS);
    localparam int FRAME_BYTES_MAX = 65536;
    localparam int IDX_W           = 16;
    localparam int ADDR_W          = $clog2(RING_SLOTS * FRAME_BYTES_MAX);
    localparam int FSIZE_W         = 17;
    localparam int WEIGHT_BITS     = 16;
    localparam int WGT_W           = WEIGHT_BITS + 1;
    localparam int DCNT_W          = $clog2(WEIGHT_BITS);
    localparam int FILL_W          = $clog2(RING_SLOTS + 1);
    localparam int TIME_W          = 64;

    // item kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_NEAREST = 2'd1;
    localparam logic [1:0] KIND_PAIR    = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NONE    = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    // pair modes
    localparam logic [1:0] MODE_BLEND   = 2'd0;
    localparam logic [1:0] MODE_EARLY   = 2'd1;
    localparam logic [1:0] MODE_LATE    = 2'd2;
    localparam logic [1:0] MODE_SINGLE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_NEAR,
        ST_PAIR,
        ST_PAIR_END,
        ST_DIV,
        ST_RD_L,
        ST_BLEND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

endpackage : tfrb_pkg
`default_nettype wire

// File: src/timestamped_frame_ring_blend_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// timestamped_frame_ring_blend_core
// Ring of timestamped frame slots with nearest lookup, pair selection with a
// fractional weight, and blended byte reads.
// ---------------------------------------------------------------------------
// states: write DISPATCH, FINISH; read DISPATCH, RD_L, BLEND, FINISH; nearest
//   DISPATCH, NEAR, FINISH; pair DISPATCH, PAIR, PAIR_END, DIV for a blend, FINISH
// throughput: one word at a time; input stalls until the result is registered
// slot scans take one slot per cycle through one compare path
// reset clears slot marks, times, ring pointers and pair state; the pixel
//   store is not cleared, so no clearing pass is needed
module timestamped_frame_ring_blend_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [tfrb_pkg::FSIZE_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  kind,
    input  wire logic [tfrb_pkg::TIME_W-1:0] time_ns,
    input  wire logic [tfrb_pkg::IDX_W-1:0]  byte_index,
    input  wire logic [7:0]                  pixel,
    input  wire logic                        last_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [2:0]                       slot,
    output logic [tfrb_pkg::TIME_W-1:0]      frame_time,
    output logic [7:0]                       pixel_out,
    output logic [1:0]                       blend_mode
);
    import tfrb_pkg::*;

    state_t state_reg, state_next;

    logic [FSIZE_W-1:0]  fsize_reg;
    logic [1:0]          kind_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [7:0]          pix_reg;
    logic                last_reg;

    logic [TIME_W-1:0]   slot_time_reg [RING_SLOTS];
    logic [RING_SLOTS-1:0] slot_valid_reg;
    logic [SLOT_W-1:0]   head_reg;
    logic [FILL_W-1:0]   filled_reg;
    logic [SLOT_W-1:0]   early_reg, late_reg;
    logic [WGT_W-1:0]    weight_reg;
    logic [1:0]          mode_reg;
    logic                pair_ready_reg;

    logic [SLOT_W-1:0]   scan_reg;
    logic                found_reg, has_l_reg;
    logic [TIME_W-1:0]   best_reg, tl_reg;
    logic [SLOT_W-1:0]   best_idx_reg;
    logic [7:0]          e_byte_reg;

    logic [1:0]          res_status_reg;
    logic [2:0]          res_slot_reg;
    logic [TIME_W-1:0]   res_time_reg;
    logic [7:0]          res_pix_reg;
    logic [1:0]          res_mode_reg;

    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [2:0]          out_slot_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [7:0]          out_pix_reg;
    logic [1:0]          out_mode_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [7:0]          ram_rdata;
    div_req_t            div_req;
    logic                div_done;
    logic [WEIGHT_BITS-1:0] div_q;

    logic                in_acc;
    logic                out_free;
    logic                idx_ok;
    logic                scan_last;
    logic [TIME_W-1:0]   cur_t;
    logic                cur_v;
    logic [TIME_W-1:0]   diff;
    logic [SLOT_W-1:0]   prev_head;
    logic [24:0]         prod_e, prod_l;
    logic [25:0]         blend_sum;

    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (scan_reg == SLOT_W'(RING_SLOTS - 1));
    assign cur_t     = slot_time_reg[scan_reg];
    assign cur_v     = slot_valid_reg[scan_reg];
    assign diff      = (cur_t > time_reg) ? cur_t - time_reg : time_reg - cur_t;
    assign prev_head = (head_reg == '0) ? SLOT_W'(RING_SLOTS - 1) : head_reg - 1'b1;

    // byte index against the clamped frame size
    always_comb
    begin
        if (fsize_reg == '0)
        begin
            idx_ok = (idx_reg == '0);
        end
        else
        begin
            idx_ok = ({1'b0, idx_reg} < fsize_reg) || (fsize_reg > FSIZE_W'(FRAME_BYTES_MAX));
        end
    end

    // blend arithmetic
    assign prod_e    = e_byte_reg * (WGT_W'(1 << WEIGHT_BITS) - weight_reg);
    assign prod_l    = ram_rdata * weight_reg;
    assign blend_sum = 26'(prod_e) + 26'(prod_l) + 26'(1 << (WEIGHT_BITS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (kind_reg)
                    KIND_WRITE:   state_next = ST_FINISH;
                    KIND_NEAREST: state_next = ST_NEAR;
                    KIND_PAIR:    state_next = (filled_reg > FILL_W'(1)) ? ST_PAIR : ST_FINISH;
                    KIND_READ:    state_next = (idx_ok && pair_ready_reg) ? ST_RD_L : ST_FINISH;
                    default:      state_next = ST_FINISH;
                endcase
            end
            ST_NEAR:     state_next = scan_last ? ST_FINISH : ST_NEAR;
            ST_PAIR:     state_next = scan_last ? ST_PAIR_END : ST_PAIR;
            ST_PAIR_END: state_next = (found_reg && has_l_reg) ? ST_DIV : ST_FINISH;
            ST_DIV:      state_next = div_done ? ST_FINISH : ST_DIV;
            ST_RD_L:     state_next = ST_BLEND;
            ST_BLEND:    state_next = ST_FINISH;
            ST_FINISH:   state_next = out_free ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        ram_we       = 1'b0;
        ram_addr     = {early_reg, idx_reg};
        div_req.start = 1'b0;
        div_req.num  = time_reg - best_reg;
        div_req.den  = tl_reg - best_reg;
        unique case (state_reg)
            ST_DISPATCH:
            begin
                if (kind_reg == KIND_WRITE)
                begin
                    ram_we   = idx_ok;
                    ram_addr = {head_reg, idx_reg};
                end
            end
            ST_RD_L:
            begin
                ram_addr = {late_reg, idx_reg};
            end
            ST_PAIR_END:
            begin
                div_req.start = found_reg && has_l_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fsize_reg      <= FSIZE_W'(FRAME_BYTES_MAX);
            slot_valid_reg <= '0;
            head_reg       <= '0;
            filled_reg     <= '0;
            early_reg      <= '0;
            late_reg       <= '0;
            weight_reg     <= '0;
            mode_reg       <= MODE_BLEND;
            pair_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < RING_SLOTS; i++)
            begin
                slot_time_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                fsize_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_DISPATCH:
                begin
                    if (kind_reg == KIND_WRITE && idx_ok)
                    begin
                        slot_valid_reg[head_reg] <= last_reg;
                        if (last_reg)
                        begin
                            slot_time_reg[head_reg] <= time_reg;
                            head_reg <= (head_reg == SLOT_W'(RING_SLOTS - 1)) ? '0
                                                                            : head_reg + 1'b1;
                            if (filled_reg < FILL_W'(RING_SLOTS))
                            begin
                                filled_reg <= filled_reg + 1'b1;
                            end
                        end
                    end
                    if (kind_reg == KIND_PAIR)
                    begin
                        pair_ready_reg <= 1'b0;
                        if (filled_reg == FILL_W'(1) && slot_valid_reg[prev_head])
                        begin
                            early_reg      <= prev_head;
                            late_reg       <= prev_head;
                            mode_reg       <= MODE_SINGLE;
                            weight_reg     <= '0;
                            pair_ready_reg <= 1'b1;
                        end
                    end
                end
                ST_PAIR_END:
                begin
                    if (found_reg || has_l_reg)
                    begin
                        early_reg      <= best_idx_reg;
                        late_reg       <= SLOT_W'(res_slot_reg);
                        weight_reg     <= '0;
                        pair_ready_reg <= 1'b1;
                        mode_reg       <= !found_reg ? MODE_LATE :
                                          !has_l_reg ? MODE_EARLY : MODE_BLEND;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        weight_reg <= {1'b0, div_q};
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // item, scan and result datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg <= kind;
            time_reg <= time_ns;
            idx_reg  <= byte_index;
            pix_reg  <= pixel;
            last_reg <= last_byte;
        end
        case (state_reg)
            ST_DISPATCH:
            begin
                scan_reg       <= '0;
                found_reg      <= 1'b0;
                has_l_reg      <= 1'b0;
                best_reg       <= '0;
                tl_reg         <= '1;
                best_idx_reg   <= '0;
                res_status_reg <= STAT_OK;
                res_slot_reg   <= '0;
                res_time_reg   <= '0;
                res_pix_reg    <= '0;
                res_mode_reg   <= MODE_BLEND;
                if ((kind_reg == KIND_WRITE || kind_reg == KIND_READ) && !idx_ok)
                begin
                    res_status_reg <= STAT_RANGE;
                end
                else if (kind_reg == KIND_READ && !pair_ready_reg)
                begin
                    res_status_reg <= STAT_NONE;
                end
                else if (kind_reg == KIND_PAIR && filled_reg <= FILL_W'(1))
                begin
                    if (filled_reg == FILL_W'(1) && slot_valid_reg[prev_head])
                    begin
                        res_mode_reg <= MODE_SINGLE;
                    end
                    else
                    begin
                        res_status_reg <= STAT_NONE;
                    end
                end
            end
            ST_NEAR:
            begin
                scan_reg <= scan_reg + 1'b1;
                if (cur_v && (!found_reg || diff < best_reg))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= diff;
                    best_idx_reg <= scan_reg;
                    res_slot_reg <= 3'(scan_reg);
                    res_time_reg <= cur_t;
                end
                if (scan_last && !(found_reg || cur_v))
                begin
                    res_status_reg <= STAT_NONE;
                end
            end
            ST_PAIR:
            begin
                // best tracks the earlier side, tl the later side
                if (!scan_last)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (cur_v && cur_t <= time_reg && cur_t >= best_reg)
                begin
                    best_reg     <= cur_t;
                    best_idx_reg <= scan_reg;
                    found_reg    <= 1'b1;
                end
                if (cur_v && cur_t > time_reg && cur_t <= tl_reg)
                begin
                    tl_reg       <= cur_t;
                    res_slot_reg <= 3'(scan_reg);
                    has_l_reg    <= 1'b1;
                end
            end
            ST_PAIR_END:
            begin
                scan_reg <= SLOT_W'(res_slot_reg);
                res_slot_reg <= '0;
                if (!found_reg && !has_l_reg)
                begin
                    res_status_reg <= STAT_NONE;
                end
                else
                begin
                    res_mode_reg <= !found_reg ? MODE_LATE :
                                    !has_l_reg ? MODE_EARLY : MODE_BLEND;
                end
            end
            ST_RD_L:
            begin
                e_byte_reg <= ram_rdata;
            end
            ST_BLEND:
            begin
                res_mode_reg <= mode_reg;
                case (mode_reg)
                    MODE_BLEND: res_pix_reg <= blend_sum[WEIGHT_BITS +: 8];
                    MODE_LATE:  res_pix_reg <= ram_rdata;
                    default:    res_pix_reg <= e_byte_reg;
                endcase
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_slot_reg   <= res_slot_reg;
                    out_time_reg   <= res_time_reg;
                    out_pix_reg    <= res_pix_reg;
                    out_mode_reg   <= res_mode_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // pixel store
    tfrb_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pix_reg),
        .rdata (ram_rdata)
    );

    // fractional divider for the pair blend weight
    tfrb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot       = out_slot_reg;
    assign frame_time = out_time_reg;
    assign pixel_out  = out_pix_reg;
    assign blend_mode = out_mode_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_W'(RING_SLOTS))
        else $error("fill count above ring size");

    a_single_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_ready_reg && mode_reg == MODE_SINGLE) |-> (early_reg == late_reg))
        else $error("single frame pair with two slots");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_DISPATCH))
        else $error("accepted word not dispatched");

    a_div_only_blend: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (kind_reg == KIND_PAIR))
        else $error("divider started outside pair selection");

endmodule : timestamped_frame_ring_blend_core
`default_nettype wire

// File: src/tfrb_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfrb_ram
// Single-port byte store with registered read data, no reset.
// ---------------------------------------------------------------------------
module tfrb_ram #(
    parameter int ADDR_W = 19,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule : tfrb_ram
`default_nettype wire

// File: src/tfrb_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfrb_div
// Restoring fractional divider: floor(num * 2^WEIGHT_BITS / den), num < den,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tfrb_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tfrb_pkg::div_req_t         req,
    output logic                            done,
    output logic [tfrb_pkg::WEIGHT_BITS-1:0] quot
);
    import tfrb_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DCNT_W-1:0]      cnt_reg, cnt_next;
    logic [TIME_W-1:0]      rem_reg, rem_next;
    logic [TIME_W-1:0]      den_reg, den_next;
    logic [WEIGHT_BITS-1:0] q_reg, q_next;
    logic [TIME_W:0]        shifted;
    logic                   take;

    // load on start, else one shift and subtract step while busy
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        take      = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.num;
            den_next  = req.den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = take ? TIME_W'(shifted - {1'b0, den_reg}) : shifted[TIME_W-1:0];
            q_next   = {q_reg[WEIGHT_BITS-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(WEIGHT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule : tfrb_div
`default_nettype wire

// File: test/timestamped_frame_ring_blend_core_test.sv
// ---------------------------------------------------------------------------
// timestamped_frame_ring_blend_core_test
// Drives write, nearest lookup, pair selection and blended read words into
// the frame ring core, predicts every result word with an own model of the
// ring and compares it field by field against the core output.
// ---------------------------------------------------------------------------
module timestamped_frame_ring_blend_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tfrb_pkg::*;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] time_ns;
        logic [IDX_W-1:0]  byte_index;
        logic [7:0]        pixel;
        logic              last_byte;
    } ring_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        slot;
        logic [TIME_W-1:0] frame_time;
        logic [7:0]        pixel_out;
        logic [1:0]        blend_mode;
    } ring_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [FSIZE_W-1:0]    cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            kind;
    logic [TIME_W-1:0]     time_ns;
    logic [IDX_W-1:0]      byte_index;
    logic [7:0]            pixel;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [2:0]            slot;
    logic [TIME_W-1:0]     frame_time;
    logic [7:0]            pixel_out;
    logic [1:0]            blend_mode;

    timestamped_frame_ring_blend_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .time_ns    (time_ns),
        .byte_index (byte_index),
        .pixel      (pixel),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .frame_time (frame_time),
        .pixel_out  (pixel_out),
        .blend_mode (blend_mode)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    logic [7:0]          pix_mem [int];
    logic [TIME_W-1:0]   ring_time [RING_SLOTS];
    logic                ring_valid [RING_SLOTS];
    int unsigned         ring_head;
    int unsigned         ring_fill;
    int unsigned         pair_early;
    int unsigned         pair_late;
    logic [WGT_W-1:0]    pair_weight;
    logic [1:0]          pair_kind;
    logic                pair_armed;
    logic [FSIZE_W-1:0]  frame_size;

    ring_word_t    pending_words [$];
    ring_result_t  expected_results [$];
    int            error_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_send;
    bit            in_acc_seen;
    longint        cycle_count;

    function automatic int unsigned active_size();
        if (frame_size == '0)
            return 1;
        if (frame_size > FRAME_BYTES_MAX)
            return FRAME_BYTES_MAX;
        return frame_size;
    endfunction

    function automatic logic [7:0] mem_byte(int unsigned s, int unsigned idx);
        int a;
        a = s * FRAME_BYTES_MAX + idx;
        if (pix_mem.exists(a))
            return pix_mem[a];
        return 8'd0;
    endfunction

    // restoring fractional division, num below den
    function automatic logic [WGT_W-1:0] weight_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] r;
        logic [WGT_W-1:0] q;
        logic top;
        r = num;
        q = '0;
        for (int b = 0; b < WEIGHT_BITS; b++)
        begin
            top = r[63];
            r = r << 1;
            q = q << 1;
            if (top || r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic ring_result_t predict_ring(ring_word_t w);
        ring_result_t res;
        int unsigned h;
        int unsigned bi;
        int unsigned ie;
        int unsigned il;
        logic found;
        logic has_e;
        logic has_l;
        logic [63:0] best;
        logic [63:0] d;
        logic [63:0] te;
        logic [63:0] tl;
        logic [7:0] e;
        logic [7:0] l;
        logic [31:0] mix;
        res = '0;
        case (w.kind)
            KIND_WRITE:
            begin
                if (w.byte_index >= active_size())
                    res.status = STAT_RANGE;
                else
                begin
                    h = ring_head;
                    pix_mem[h * FRAME_BYTES_MAX + w.byte_index] = w.pixel;
                    ring_valid[h] = 1'b0;
                    if (w.last_byte)
                    begin
                        ring_time[h] = w.time_ns;
                        ring_valid[h] = 1'b1;
                        ring_head = (h + 1) % RING_SLOTS;
                        if (ring_fill < RING_SLOTS)
                            ring_fill++;
                    end
                end
            end
            KIND_NEAREST:
            begin
                found = 1'b0;
                best = '1;
                bi = 0;
                for (int i = 0; i < RING_SLOTS; i++)
                begin
                    if (ring_valid[i])
                    begin
                        d = ring_time[i] > w.time_ns ? ring_time[i] - w.time_ns
                                                     : w.time_ns - ring_time[i];
                        if (!found || d < best)
                        begin
                            best = d;
                            bi = i;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    res.status = STAT_NONE;
                else
                begin
                    res.slot = bi[2:0];
                    res.frame_time = ring_time[bi];
                end
            end
            KIND_PAIR:
            begin
                pair_armed = 1'b0;
                if (ring_fill == 0)
                    res.status = STAT_NONE;
                else if (ring_fill == 1)
                begin
                    h = (ring_head + RING_SLOTS - 1) % RING_SLOTS;
                    if (!ring_valid[h])
                        res.status = STAT_NONE;
                    else
                    begin
                        pair_early = h;
                        pair_late = h;
                        pair_kind = MODE_SINGLE;
                        pair_weight = '0;
                        pair_armed = 1'b1;
                    end
                end
                else
                begin
                    has_e = 1'b0;
                    has_l = 1'b0;
                    te = '0;
                    tl = '1;
                    ie = 0;
                    il = 0;
                    for (int i = 0; i < RING_SLOTS; i++)
                    begin
                        if (ring_valid[i])
                        begin
                            if (ring_time[i] <= w.time_ns && ring_time[i] >= te)
                            begin
                                te = ring_time[i];
                                ie = i;
                                has_e = 1'b1;
                            end
                            if (ring_time[i] > w.time_ns && ring_time[i] <= tl)
                            begin
                                tl = ring_time[i];
                                il = i;
                                has_l = 1'b1;
                            end
                        end
                    end
                    if (!has_e && !has_l)
                        res.status = STAT_NONE;
                    else
                    begin
                        pair_early = ie;
                        pair_late = il;
                        pair_weight = '0;
                        if (!has_e)
                            pair_kind = MODE_LATE;
                        else if (!has_l)
                            pair_kind = MODE_EARLY;
                        else
                        begin
                            pair_kind = MODE_BLEND;
                            pair_weight = weight_div(w.time_ns - te, tl - te);
                        end
                        pair_armed = 1'b1;
                    end
                end
                if (res.status == STAT_OK)
                    res.blend_mode = pair_kind;
            end
            default:
            begin
                if (w.byte_index >= active_size())
                    res.status = STAT_RANGE;
                else if (!pair_armed)
                    res.status = STAT_NONE;
                else
                begin
                    e = mem_byte(pair_early, w.byte_index);
                    l = mem_byte(pair_late, w.byte_index);
                    res.blend_mode = pair_kind;
                    if (pair_kind == MODE_BLEND)
                    begin
                        mix = e * ((32'd1 << WEIGHT_BITS) - pair_weight)
                            + l * pair_weight + (32'd1 << (WEIGHT_BITS - 1));
                        res.pixel_out = mix >> WEIGHT_BITS;
                    end
                    else if (pair_kind == MODE_LATE)
                        res.pixel_out = l;
                    else
                        res.pixel_out = e;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // driver: present words at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_acc_seen)
            begin
                if (in_valid)
                    void'(pending_words.pop_front());
                if (pending_words.size() > 0 &&
                    (!hold_send || expected_results.size() == 0) &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    kind       <= pending_words[0].kind;
                    time_ns    <= pending_words[0].time_ns;
                    byte_index <= pending_words[0].byte_index;
                    pixel      <= pending_words[0].pixel;
                    last_byte  <= pending_words[0].last_byte;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: predict accepted inputs and check accepted outputs
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            in_acc_seen = in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_results.push_back(predict_ring({kind, time_ns, byte_index,
                                                         pixel, last_byte}));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result word at cycle %0d", cycle_count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (frame_time !== want.frame_time)
                        report_mismatch("frame_time", frame_time, want.frame_time);
                    if (pixel_out !== want.pixel_out)
                        report_mismatch("pixel_out", pixel_out, want.pixel_out);
                    if (blend_mode !== want.blend_mode)
                        report_mismatch("blend_mode", blend_mode, want.blend_mode);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("timestamped_frame_ring_blend_core_test: done, errors");
            $finish;
        end
    end

    function automatic ring_word_t make_word(logic [1:0] k, logic [63:0] t, int idx,
                                             logic [7:0] p, logic lb);
        ring_word_t w;
        w.kind = k;
        w.time_ns = t;
        w.byte_index = idx;
        w.pixel = p;
        w.last_byte = lb;
        return w;
    endfunction

    function automatic logic [63:0] rand_time();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'd1000 * $urandom_range(40);
            2: return 64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(15);
            default: return $urandom_range(50);
        endcase
    endfunction

    // a whole frame, written with every byte so reads never see unwritten data
    task automatic queue_frame(int unsigned fs, logic [63:0] t);
        for (int i = 0; i < fs; i++)
            pending_words.push_back(make_word(KIND_WRITE, t, i, $urandom, i == fs - 1));
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_frame_size(logic [FSIZE_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        frame_size = v;
    endtask

    // random stimulus: whole frames mixed with lookups, pair selections and reads
    task automatic queue_random(int unsigned count, int unsigned fs);
        int unsigned n;
        int unsigned r;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                queue_frame(fs, rand_time());
                n += fs;
            end
            else if (r < 50)
                pending_words.push_back(make_word(KIND_NEAREST, rand_time(), $urandom,
                                                  $urandom, $urandom));
            else if (r < 65)
                pending_words.push_back(make_word(KIND_PAIR, rand_time(), $urandom,
                                                  $urandom, $urandom));
            else if (r < 95)
                pending_words.push_back(make_word(KIND_READ, rand_time(),
                                                  $urandom_range(fs - 1), $urandom,
                                                  $urandom));
            else
                // out of range noise on write or read
                pending_words.push_back(make_word($urandom_range(1) ? KIND_READ : KIND_WRITE,
                                                  rand_time(),
                                                  fs + $urandom_range(65535 - fs),
                                                  $urandom, $urandom));
            n++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_WRITE;
        time_ns = '0;
        byte_index = '0;
        pixel = '0;
        last_byte = 1'b0;
        out_stall = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_send = 1'b0;
        in_acc_seen = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 50;
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            ring_time[i] = '0;
            ring_valid[i] = 1'b0;
        end
        ring_head = 0;
        ring_fill = 0;
        pair_early = 0;
        pair_late = 0;
        pair_weight = '0;
        pair_kind = MODE_BLEND;
        pair_armed = 1'b0;
        frame_size = 17'd65536;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty ring, range errors, single frame, blend pair, one-sided pairs
        set_frame_size(17'd2);
        pending_words.push_back(make_word(KIND_NEAREST, 64'd5, 0, 0, 0));
        pending_words.push_back(make_word(KIND_PAIR, 64'd5, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_WRITE, 64'd0, 2, 8'hFF, 1));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 16'hFFFF, 0, 0));
        queue_frame(2, 64'd100);
        pending_words.push_back(make_word(KIND_PAIR, 64'd0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 1, 0, 0));
        pending_words.push_back(make_word(KIND_WRITE, 64'd300, 0, 8'h00, 0));
        pending_words.push_back(make_word(KIND_WRITE, 64'd300, 1, 8'hFF, 1));
        pending_words.push_back(make_word(KIND_PAIR, 64'd250, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 1, 0, 0));
        pending_words.push_back(make_word(KIND_PAIR, 64'd50, 0, 0, 0));
        pending_words.push_back(make_word(KIND_PAIR, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 1, 0, 0));
        pending_words.push_back(make_word(KIND_NEAREST, 64'd200, 0, 0, 0));
        pending_words.push_back(make_word(KIND_NEAREST, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
        pending_words.push_back(make_word(KIND_WRITE, 64'd0, 0, 8'h5A, 0));
        pending_words.push_back(make_word(KIND_NEAREST, 64'd0, 0, 0, 0));
        wait_drained();

        // sender pauses until all results are in
        hold_send = 1'b1;
        queue_random(300, 2);
        wait_drained();
        hold_send = 1'b0;
        wait_drained();

        send_idle_pct = 50;
        recv_idle_pct = 19;
        set_frame_size(17'd0);
        queue_random(250, 1);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_frame_size(17'd3);
        // refill every slot so each valid frame holds all three bytes
        for (int i = 0; i < RING_SLOTS; i++)
            queue_frame(3, rand_time());
        queue_random(200, 3);
        wait_drained();

        // largest sizes, used briefly with range edges
        set_frame_size(17'h1FFFF);
        // every slot gets the two top bytes before they are read
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            pending_words.push_back(make_word(KIND_WRITE, 64'd3, 16'hFFFE, $urandom, 0));
            pending_words.push_back(make_word(KIND_WRITE, 64'd3, 16'hFFFF, $urandom, 1));
        end
        pending_words.push_back(make_word(KIND_WRITE, 64'd7, 16'hFFFF, 8'hA5, 1));
        pending_words.push_back(make_word(KIND_PAIR, 64'd7, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 16'hFFFF, 0, 0));
        pending_words.push_back(make_word(KIND_NEAREST, 64'd0, 0, 0, 0));
        wait_drained();
        set_frame_size(17'd65535);
        pending_words.push_back(make_word(KIND_WRITE, 64'd9, 16'hFFFF, 8'h11, 1));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 16'hFFFF, 0, 0));
        pending_words.push_back(make_word(KIND_WRITE, 64'd9, 16'hFFFE, 8'h22, 1));
        pending_words.push_back(make_word(KIND_PAIR, 64'd9, 0, 0, 0));
        pending_words.push_back(make_word(KIND_READ, 64'd0, 16'hFFFE, 0, 0));
        wait_drained();

        if (error_count == 0)
            $display("timestamped_frame_ring_blend_core_test: done, clean");
        else
            $display("timestamped_frame_ring_blend_core_test: done, errors");
        $finish;
    end

endmodule

// File: files.f
src/tfrb_pkg.sv
src/tfrb_ram.sv
src/tfrb_div.sv
src/timestamped_frame_ring_blend_core.sv
test/timestamped_frame_ring_blend_core_test.sv
